>>> design/pip_pkg.sv
package pip_pkg;

  // Store geometry and coordinate format
  localparam int MAX_VERTICES = 32;
  localparam int COORD_BITS   = 12;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 6;
  localparam int MIN_POLY     = 3;
  localparam int VERT_W       = 2 * COORD_BITS;
  localparam int DIFF_W       = COORD_BITS + 1;
  localparam int PROD_W       = 2 * DIFF_W;

  // Opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [4:0]            vertex_index;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
  } in_word_t;

  typedef struct packed {
    logic inside_res;
    logic was_query;
  } out_word_t;

  // Controller to datapath
  typedef struct packed {
    logic             mem_we;
    logic             load_pt;
    logic             clr_inside;
    logic             rd_en;
    logic             rd_first;
    logic [IDX_W-1:0] rd_addr;
  } pip_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic busy;
    logic inside_flag;
  } pip_stat_t;

endpackage

>>> design/pip_ram.sv
module pip_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/pip_datapath.sv
module pip_datapath
  import pip_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_word_t  in_word,
  input  pip_cmd_t  cmd,
  output pip_stat_t stat
);

  logic [VERT_W-1:0]     rd_data;
  logic [COORD_BITS-1:0] cur_x, cur_y;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic [COORD_BITS-1:0] prev_x_r, prev_y_r;
  logic                  rd_pend_r, first_pend_r;
  logic                  s1_r;
  logic                  straddle_r, dy_pos_r;
  logic signed [PROD_W-1:0] lhs_r, rhs_r;
  logic                  inside_r;
  logic signed [DIFF_W-1:0] dy, dxp, dxe, dyp;
  logic                  straddle;
  logic                  crosses;
  logic [IDX_W-1:0]      wr_addr;

  assign wr_addr = in_word.vertex_index[IDX_W-1:0];

  // Vertex store: x in the upper half, y in the lower half
  pip_ram #(
    .WIDTH (VERT_W),
    .DEPTH (MAX_VERTICES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.mem_we),
    .waddr (wr_addr),
    .wdata ({in_word.coord_x, in_word.coord_y}),
    .re    (cmd.rd_en),
    .raddr (cmd.rd_addr),
    .rdata (rd_data)
  );

  assign cur_x = rd_data[VERT_W-1:COORD_BITS];
  assign cur_y = rd_data[COORD_BITS-1:0];

  // Edge terms: current vertex i against previous vertex j
  always_comb begin
    straddle = (cur_y > py_r) != (prev_y_r > py_r);
    dy  = $signed({1'b0, prev_y_r}) - $signed({1'b0, cur_y});
    dxp = $signed({1'b0, px_r})     - $signed({1'b0, cur_x});
    dxe = $signed({1'b0, prev_x_r}) - $signed({1'b0, cur_x});
    dyp = $signed({1'b0, py_r})     - $signed({1'b0, cur_y});
  end

  // Track outstanding reads and hold the query point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r    <= 1'b0;
      first_pend_r <= 1'b0;
      s1_r         <= 1'b0;
    end else begin
      rd_pend_r    <= cmd.rd_en;
      first_pend_r <= cmd.rd_first;
      s1_r         <= rd_pend_r & ~first_pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      px_r <= in_word.coord_x;
      py_r <= in_word.coord_y;
    end
    // Advance the previous vertex and register both cross products
    if (rd_pend_r) begin
      prev_x_r   <= cur_x;
      prev_y_r   <= cur_y;
      straddle_r <= straddle;
      dy_pos_r   <= prev_y_r > cur_y;
      lhs_r      <= dxp * dy;
      rhs_r      <= dxe * dyp;
    end
  end

  // Crossing test with direction set by the sign of the y difference
  assign crosses = straddle_r & (dy_pos_r ? (lhs_r < rhs_r) : (lhs_r > rhs_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
    end else if (cmd.clr_inside) begin
      inside_r <= 1'b0;
    end else if (s1_r && crosses) begin
      inside_r <= ~inside_r;
    end
  end

  assign stat.busy        = rd_pend_r | s1_r;
  assign stat.inside_flag = inside_r;

endmodule

>>> design/pip_ctrl.sv
module pip_ctrl
  import pip_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_word_t         in_word,
  output logic             in_stall,
  output logic             out_valid,
  output out_word_t        out_word,
  input  logic             out_stall,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  pip_stat_t        stat,
  output pip_cmd_t         cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             res_r, res_nxt;
  logic             qry_r, qry_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_word_r, out_word_nxt;
  logic             accept;
  logic [CNT_W-1:0] last_idx;
  logic [CNT_W-1:0] prev_cnt;

  // Clamp the vertex count to the store depth
  assign n_eff    = (count_r > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_r;
  assign last_idx = n_eff - CNT_W'(1);
  assign prev_cnt = cnt_r - CNT_W'(1);

  assign in_stall = state_r != S_IDLE;
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    res_nxt        = res_r;
    qry_nxt        = qry_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_word_nxt   = out_word_r;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_word.opcode == OP_WRITE) begin
            cmd.mem_we = 32'(in_word.vertex_index) < MAX_VERTICES;
            res_nxt    = 1'b0;
            qry_nxt    = 1'b0;
            state_nxt  = S_DONE;
          end else begin
            cmd.load_pt    = 1'b1;
            cmd.clr_inside = 1'b1;
            qry_nxt        = 1'b1;
            if (n_eff < CNT_W'(MIN_POLY)) begin
              res_nxt   = 1'b0;
              state_nxt = S_DONE;
            end else begin
              cnt_nxt   = '0;
              state_nxt = S_RUN;
            end
          end
        end
      end
      S_RUN: begin
        // Read the closing vertex first, then vertices 0 through n-1
        cmd.rd_en    = 1'b1;
        cmd.rd_first = cnt_r == '0;
        cmd.rd_addr  = (cnt_r == '0) ? last_idx[IDX_W-1:0] : prev_cnt[IDX_W-1:0];
        cnt_nxt      = cnt_r + CNT_W'(1);
        if (cnt_r == n_eff) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!stat.busy) begin
          res_nxt   = stat.inside_flag;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hand the word over once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_word_nxt.inside_res = res_r;
          out_word_nxt.was_query  = qry_r;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    res_r      <= res_nxt;
    qry_r      <= qry_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

>>> design/point_in_polygon_test.sv
// Even-odd ray-casting test of a point against one stored polygon.
// Input channel (in_valid / in_stall / in_word): a write word stores one
// vertex at vertex_index; a query word tests the point (coord_x, coord_y)
// against the first vertex_count stored vertices, the last closing the ring.
// Output channel (out_valid / out_stall / out_word): one word per input word;
// was_query tells a query answer from a write acknowledge.
// Config port (cfg_we / cfg_wdata) sets vertex_count; write it only while idle.
// A write, and a query with fewer than three vertices, go straight to the done
// state; any other query makes one store read per cycle (n + 1 reads for n
// vertices) and passes a three-stage edge pipeline before it is answered.
// One word is in work at a time; the next is accepted once the result has
// moved into the output register.
// Reset (rst_n low, synchronous) clears vertex_count and the output valid;
// the vertex store is not cleared and must be written before it is queried.
// A stalled output word holds; the block keeps accepting one more word and
// then stalls its input until the output register frees up.
module point_in_polygon_test
  import pip_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  in_word_t         in_word,
  output logic             in_stall,
  output logic             out_valid,
  output out_word_t        out_word,
  input  logic             out_stall,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  pip_cmd_t  cmd;
  pip_stat_t stat;

  pip_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stat      (stat),
    .cmd       (cmd)
  );

  pip_datapath u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_word (in_word),
    .cmd     (cmd),
    .stat    (stat)
  );

endmodule

>>> tb/point_in_polygon_test_test.sv
module point_in_polygon_test_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pip_pkg::*;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int SETTLE_CYCLES  = MAX_VERTICES + 8;
  localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
  localparam int HOLDOFF_CYCLES = 200;

  logic             clk       = 1'b0;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  in_word_t         in_word   = '0;
  logic             in_stall;
  logic             out_valid;
  out_word_t        out_word;
  logic             out_stall = 1'b0;
  logic             cfg_we    = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int holdoff_req    = 0;
  int holdoff_seen   = 0;
  int holdoff_left   = 0;
  int words_accepted = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  // Answers still owed by the block, oldest first
  out_word_t expected_answers[$];

  // Shadow of the polygon store and the vertex count register
  logic [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  bit                    vertex_written [MAX_VERTICES];
  logic [CNT_W-1:0]      poly_count = '0;

  point_in_polygon_test i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Even-odd crossing count over the active ring, exact cross-multiplication
  function automatic logic point_inside(int px, int py);
    int     n;
    int     j;
    longint xi, yi, xj, yj, dy, lhs, rhs;
    logic   odd;
    n = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    if (n < MIN_POLY) return 1'b0;
    odd = 1'b0;
    j = n - 1;
    for (int i = 0; i < n; i++) begin
      xi = poly_x[i];
      yi = poly_y[i];
      xj = poly_x[j];
      yj = poly_y[j];
      // only edges that straddle the query's y can toggle
      if ((yi > py) != (yj > py)) begin
        dy  = yj - yi;
        lhs = (px - xi) * dy;
        rhs = (xj - xi) * (py - yi);
        if ((dy > 0) ? (lhs < rhs) : (lhs > rhs)) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  // Apply one accepted word to the shadow store and give its answer
  function automatic out_word_t answer_for(in_word_t w);
    out_word_t r;
    if (w.opcode == OP_WRITE) begin
      poly_x[w.vertex_index]         = w.coord_x;
      poly_y[w.vertex_index]         = w.coord_y;
      vertex_written[w.vertex_index] = 1'b1;
      r.inside_res = 1'b0;
      r.was_query  = 1'b0;
    end else begin
      r.inside_res = point_inside(w.coord_x, w.coord_y);
      r.was_query  = 1'b1;
    end
    return r;
  endfunction

  // Offer one word, with random gaps before it, and hold it until taken
  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    expected_answers = {expected_answers, answer_for(w)};
    words_accepted++;
  endtask

  task automatic send_vertex(input int idx, input int x, input int y);
    in_word_t w;
    w.opcode       = OP_WRITE;
    w.vertex_index = idx[4:0];
    w.coord_x      = x[COORD_BITS-1:0];
    w.coord_y      = y[COORD_BITS-1:0];
    send_word(w);
  endtask

  task automatic send_query(input int x, input int y);
    in_word_t w;
    w.opcode       = OP_QUERY;
    w.vertex_index = 5'($urandom_range(31));
    w.coord_x      = x[COORD_BITS-1:0];
    w.coord_y      = y[COORD_BITS-1:0];
    send_word(w);
  endtask

  // Drop valid, wait for every answer, then let the block settle
  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (expected_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_vertex_count(input int n);
    wait_until_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= n[CNT_W-1:0];
    @(posedge clk);
    cfg_we     <= 1'b0;
    poly_count = n[CNT_W-1:0];
  endtask

  // Full-range square, plus a write at the top store index
  task automatic test_square_directed();
    set_vertex_count(4);
    send_vertex(0, 0, 0);
    send_vertex(1, COORD_MAX, 0);
    send_vertex(2, COORD_MAX, COORD_MAX);
    send_vertex(3, 0, COORD_MAX);
    send_vertex(31, COORD_MAX, COORD_MAX);
    send_query(2048, 2048);
    send_query(0, 2048);
    send_query(COORD_MAX, 2048);
    send_query(2048, 0);
    send_query(2048, COORD_MAX);
    send_query(0, 0);
    send_query(COORD_MAX, COORD_MAX);
  endtask

  // Counts below three answer outside; three gives a triangle
  task automatic test_few_vertices();
    set_vertex_count(0);
    send_query(2048, 2048);
    set_vertex_count(1);
    send_query(2048, 2048);
    set_vertex_count(2);
    send_query(2048, 2048);
    set_vertex_count(3);
    send_query(3000, 1000);
    send_query(1000, 3000);
    send_query(COORD_MAX, 2048);
  endtask

  // Rounds of: set count, load a random polygon, query it with some stray writes
  task automatic test_random_polygons(input int stop_at);
    int pick, n_cfg, nv, n_ops, k;
    int x_lo, x_hi, y_lo, y_hi, x, y, prev_y;
    while (words_accepted < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 4)       n_cfg = $urandom_range(2);
      else if (pick < 9)  n_cfg = $urandom_range(63, MAX_VERTICES + 1);
      else if (pick < 20) n_cfg = $urandom_range(MAX_VERTICES, 13);
      else                n_cfg = $urandom_range(12, MIN_POLY);
      nv = (n_cfg > MAX_VERTICES) ? MAX_VERTICES : n_cfg;
      if (nv < MIN_POLY) nv = MIN_POLY;
      set_vertex_count(n_cfg);

      // bounding box of this polygon
      if ($urandom_range(99) < 25) begin
        x_lo = 0;
        x_hi = COORD_MAX;
        y_lo = 0;
        y_hi = COORD_MAX;
      end else begin
        x_lo = $urandom_range(COORD_MAX);
        x_hi = $urandom_range(COORD_MAX, x_lo);
        y_lo = $urandom_range(COORD_MAX);
        y_hi = $urandom_range(COORD_MAX, y_lo);
      end

      // load the ring, now and then repeating a y for a horizontal edge
      prev_y = y_lo;
      for (int i = 0; i < nv; i++) begin
        x = $urandom_range(x_hi, x_lo);
        y = $urandom_range(y_hi, y_lo);
        if (i > 0 && $urandom_range(99) < 15) y = prev_y;
        send_vertex(i, x, y);
        prev_y = y;
      end

      n_ops = $urandom_range(16, 4);
      for (int q = 0; q < n_ops; q++) begin
        pick = $urandom_range(99);
        k    = $urandom_range(nv - 1);
        if (pick < 10)
          send_vertex($urandom_range(MAX_VERTICES - 1), $urandom_range(COORD_MAX),
                      $urandom_range(COORD_MAX));
        else if (pick < 50)
          send_query($urandom_range(x_hi, x_lo), $urandom_range(y_hi, y_lo));
        else if (pick < 62)
          send_query(poly_x[k], poly_y[k]);
        else if (pick < 78)
          send_query($urandom_range(x_hi, x_lo), poly_y[k]);
        else
          send_query($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
      end
    end
  endtask

  // Hold the receiver off while words keep coming, then pause until drained
  task automatic test_backpressure();
    wait_until_drained();
    holdoff_req++;
    for (int i = 0; i < 12; i++) begin
      if (i % 4 == 3)
        send_vertex($urandom_range(MAX_VERTICES - 1), $urandom_range(COORD_MAX),
                    $urandom_range(COORD_MAX));
      else
        send_query($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    end
    wait_until_drained();
  endtask

  // Counts above the store size behave as a full store
  task automatic test_count_saturation();
    for (int i = 0; i < MAX_VERTICES; i++)
      if (!vertex_written[i])
        send_vertex(i, $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    set_vertex_count(63);
    repeat (3) send_query($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    set_vertex_count(MAX_VERTICES + 1);
    repeat (2) send_query($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
    set_vertex_count(MAX_VERTICES);
    repeat (2) send_query($urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
  endtask

  // Drive the result-side stall: long hold-off when asked, else random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (holdoff_req != holdoff_seen) begin
        holdoff_seen = holdoff_req;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        out_stall    <= 1'b1;
        holdoff_left = holdoff_left - 1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Compare each taken result word with the oldest answer owed
  always @(posedge clk) begin : check_answers
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_answers.size() == 0) begin
        $error("out_word: none pending, got inside_res=%0b was_query=%0b",
               out_word.inside_res, out_word.was_query);
        error_count++;
      end else begin
        want = expected_answers.pop_front();
        if (out_word.inside_res !== want.inside_res) begin
          $error("inside_res: expected %0b, got %0b", want.inside_res,
                 out_word.inside_res);
          error_count++;
        end
        if (out_word.was_query !== want.was_query) begin
          $error("was_query: expected %0b, got %0b", want.was_query,
                 out_word.was_query);
          error_count++;
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 20;
    recv_idle_pct = 66;
    test_square_directed();
    test_few_vertices();
    test_random_polygons(700);
    test_backpressure();

    send_idle_pct = 66;
    recv_idle_pct = 20;
    test_random_polygons(1400);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_polygons(2000);
    test_count_saturation();

    wait_until_drained();
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/pip_pkg.sv
design/pip_ram.sv
design/pip_datapath.sv
design/pip_ctrl.sv
design/point_in_polygon_test.sv
tb/point_in_polygon_test_test.sv
